### design/mctp_pkg.sv
// package for the multi-channel tick pwm block
// field widths, default sizes and operation / status codes; no dependencies
`default_nettype none

package mctp_pkg;

  localparam int unsigned NumChannelsDef = 16;
  localparam int unsigned CountWidthDef  = 16;

  localparam int unsigned ChanW   = 4;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned LevelsW = 16;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_e;

  typedef enum logic {
    STATUS_OK     = 1'b0,
    STATUS_REJECT = 1'b1
  } status_e;

endpackage

`default_nettype wire

### design/multi_channel_tick_pwm.sv
// multi-channel pwm driven by a base tick: item register, channel state, result register
// an accepted item moves from the item register into the result register when it advances
// throughput: one item per cycle while results are taken; every channel updates in parallel in one pass
// a waiting result stalls intake once the item register also holds an item
// reset clears all channel state: every channel disabled, all levels low
// depends on mctp_pkg
`default_nettype none

module multi_channel_tick_pwm
  import mctp_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef,
  parameter int unsigned COUNT_WIDTH  = CountWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                operation_i,
  input  wire logic [ChanW-1:0]    channel_i,
  input  wire logic [ValueW-1:0]   period_i,
  input  wire logic [ValueW-1:0]   duty_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [LevelsW-1:0]       levels_o,
  output logic                     status_o,
  output logic                     toggling_o
);

  localparam int unsigned CmpW = (COUNT_WIDTH > ValueW) ? COUNT_WIDTH : ValueW;

  // item register
  logic              in_valid_q;
  op_e               op_q;
  logic [ChanW-1:0]  chan_q;
  logic [ValueW-1:0] per_in_q;
  logic [ValueW-1:0] dut_in_q;

  // result register
  logic               out_valid_q;
  logic [LevelsW-1:0] levels_q, levels_d;
  status_e            status_q, status_d;
  logic               tog_q, tog_d;

  // channel state
  logic [NUM_CHANNELS-1:0] en_q, en_d;
  logic [NUM_CHANNELS-1:0] phase_q, phase_d;
  logic [NUM_CHANNELS-1:0] lvl_q, lvl_d;
  logic [NUM_CHANNELS-1:0] run_d;
  logic [ValueW-1:0]       per_q [NUM_CHANNELS];
  logic [ValueW-1:0]       per_d [NUM_CHANNELS];
  logic [ValueW-1:0]       dut_q [NUM_CHANNELS];
  logic [ValueW-1:0]       dut_d [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  cnt_q [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  cnt_d [NUM_CHANNELS];

  logic advance;
  logic is_set;
  logic reject;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q     <= op_e'(operation_i);
      chan_q   <= channel_i;
      per_in_q <= period_i;
      dut_in_q <= duty_i;
    end
  end

  assign is_set = (op_q == OP_SET);
  assign reject = is_set && ((32'(chan_q) >= NUM_CHANNELS) ||
                  ((per_in_q != '0) && ((per_in_q == ValueW'(1)) || (dut_in_q > per_in_q))));

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    logic                   hit;
    logic                   running;
    logic [COUNT_WIDTH-1:0] cnt_dec;
    logic [ValueW-1:0]      b_per, b_dut;
    logic [COUNT_WIDTH-1:0] b_cnt;
    logic                   b_phase, b_lvl;

    assign hit     = is_set && !reject && (32'(chan_q) == c);
    assign running = en_q[c] && (per_q[c] != '0) && (dut_q[c] != '0) && (dut_q[c] != per_q[c]);
    assign cnt_dec = cnt_q[c] - COUNT_WIDTH'(1);

    // a channel not yet enabled starts from cleared state
    assign b_per   = en_q[c] ? per_q[c] : '0;
    assign b_dut   = en_q[c] ? dut_q[c] : '0;
    assign b_cnt   = en_q[c] ? cnt_q[c] : '0;
    assign b_phase = en_q[c] & phase_q[c];
    assign b_lvl   = en_q[c] & lvl_q[c];

    always_comb begin
      en_d[c]    = en_q[c];
      per_d[c]   = per_q[c];
      dut_d[c]   = dut_q[c];
      cnt_d[c]   = cnt_q[c];
      phase_d[c] = phase_q[c];
      lvl_d[c]   = lvl_q[c];
      unique case (op_q)
        OP_SET: begin
          if (hit) begin
            if (per_in_q == '0) begin
              en_d[c]    = 1'b0;
              per_d[c]   = '0;
              dut_d[c]   = '0;
              cnt_d[c]   = '0;
              phase_d[c] = 1'b0;
              lvl_d[c]   = 1'b0;
            end else begin
              en_d[c]    = 1'b1;
              per_d[c]   = b_per;
              dut_d[c]   = b_dut;
              cnt_d[c]   = b_cnt;
              phase_d[c] = b_phase;
              lvl_d[c]   = b_lvl;
              if (!((b_per == per_in_q) && (b_dut == dut_in_q))) begin
                per_d[c] = per_in_q;
                dut_d[c] = dut_in_q;
                if ((b_cnt == '0) || (CmpW'(b_cnt) > CmpW'(per_in_q))) begin
                  phase_d[c] = 1'b1;
                  lvl_d[c]   = 1'b1;
                  cnt_d[c]   = COUNT_WIDTH'(dut_in_q);
                end
                // static level
                if ((dut_in_q == '0) || (dut_in_q == per_in_q)) begin
                  lvl_d[c] = (dut_in_q == per_in_q);
                end
              end
            end
          end
        end
        OP_TICK: begin
          if (running) begin
            if (cnt_dec == '0) begin
              phase_d[c] = ~phase_q[c];
              lvl_d[c]   = ~phase_q[c];
              cnt_d[c]   = phase_q[c] ? COUNT_WIDTH'(per_q[c] - dut_q[c])
                                      : COUNT_WIDTH'(dut_q[c]);
            end else begin
              cnt_d[c] = cnt_dec;
            end
          end
        end
        default: begin
        end
      endcase
    end

    assign run_d[c] = en_d[c] && (per_d[c] != '0) && (dut_d[c] != '0) &&
                      (dut_d[c] != per_d[c]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        en_q[c]    <= 1'b0;
        per_q[c]   <= '0;
        dut_q[c]   <= '0;
        cnt_q[c]   <= '0;
        phase_q[c] <= 1'b0;
        lvl_q[c]   <= 1'b0;
      end else if (advance) begin
        en_q[c]    <= en_d[c];
        per_q[c]   <= per_d[c];
        dut_q[c]   <= dut_d[c];
        cnt_q[c]   <= cnt_d[c];
        phase_q[c] <= phase_d[c];
        lvl_q[c]   <= lvl_d[c];
      end
    end
  end

  for (genvar b = 0; b < LevelsW; b++) begin : g_lvl
    if (b < NUM_CHANNELS) begin : g_used
      assign levels_d[b] = lvl_d[b];
    end else begin : g_unused
      assign levels_d[b] = 1'b0;
    end
  end

  assign status_d = reject ? STATUS_REJECT : STATUS_OK;
  assign tog_d    = |run_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      levels_q <= levels_d;
      status_q <= status_d;
      tog_q    <= tog_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign levels_o    = levels_q;
  assign status_o    = status_q;
  assign toggling_o  = tog_q;

  // a rejected set leaves every channel untouched
  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && reject |=> $stable(en_q) && $stable(lvl_q) && $stable(phase_q))
    else $error("rejected set changed channel state");

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chk
    // disabled channels hold cleared state
    a_disabled_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !en_q[c] |-> (cnt_q[c] == '0) && !phase_q[c] && !lvl_q[c] && (per_q[c] == '0))
      else $error("disabled channel holds stale state");

    // the counter of an enabled channel never exceeds its period
    a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      en_q[c] |-> (CmpW'(cnt_q[c]) <= CmpW'(per_q[c])))
      else $error("channel counter above period");
  end

endmodule

`default_nettype wire

### bench/tb.sv
// testbench for multi_channel_tick_pwm: directed and random ticks and set commands,
// a per-item channel predictor and an in-order result check
// depends on mctp_pkg and multi_channel_tick_pwm
`default_nettype none

module tb;
  import mctp_pkg::*;

  localparam int unsigned NChan      = NumChannelsDef;
  localparam int unsigned RandItems  = 1450;
  localparam int unsigned IdlePct    = 28;
  localparam int unsigned CalmFrom   = 700;
  localparam int unsigned CalmTo     = 900;
  localparam int unsigned HoldAt     = 300;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned DrainWait  = 10;

  typedef struct packed {
    op_e               op;
    logic [ChanW-1:0]  chan;
    logic [ValueW-1:0] period;
    logic [ValueW-1:0] duty;
  } pwm_cmd_t;

  typedef struct packed {
    logic [LevelsW-1:0] levels;
    status_e            status;
    logic               toggling;
  } pwm_out_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              operation_i = 1'b0;
  logic [ChanW-1:0]  channel_i = '0;
  logic [ValueW-1:0] period_i = '0;
  logic [ValueW-1:0] duty_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [LevelsW-1:0] levels_o;
  logic              status_o;
  logic              toggling_o;

  multi_channel_tick_pwm dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .channel_i  (channel_i),
    .period_i   (period_i),
    .duty_i     (duty_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .levels_o   (levels_o),
    .status_o   (status_o),
    .toggling_o (toggling_o)
  );

  always #1 clk_i = ~clk_i;

  // predicted channel state
  logic                     chan_en     [NChan];
  logic [ValueW-1:0]        chan_period [NChan];
  logic [ValueW-1:0]        chan_duty   [NChan];
  logic [CountWidthDef-1:0] chan_count  [NChan];
  logic                     chan_phase  [NChan];
  logic                     chan_level  [NChan];

  pwm_cmd_t cmd_q[$];
  pwm_out_t pending_results[$];

  int unsigned total_items;
  int unsigned accepted;
  int unsigned checked;
  int unsigned errors;
  int unsigned n_ticks;
  int unsigned n_sets;
  int unsigned n_rejected;
  int unsigned n_toggling;
  int unsigned stall_cycles;
  bit          in_taken;
  bit          hold_done;
  int unsigned hold_left;

  wire calm = (accepted >= CalmFrom) && (accepted < CalmTo);

  function automatic bit chan_running(int c);
    return chan_en[c] && chan_period[c] != '0 && chan_duty[c] != '0 &&
           chan_duty[c] != chan_period[c];
  endfunction

  function automatic void chan_clear(int c);
    chan_en[c]     = 1'b0;
    chan_period[c] = '0;
    chan_duty[c]   = '0;
    chan_count[c]  = '0;
    chan_phase[c]  = 1'b0;
    chan_level[c]  = 1'b0;
  endfunction

  function automatic pwm_out_t pwm_predict(pwm_cmd_t cmd);
    pwm_out_t r;
    int c;
    r.levels   = '0;
    r.status   = STATUS_OK;
    r.toggling = 1'b0;
    c = int'(cmd.chan);
    if (cmd.op == OP_SET) begin
      if (c >= NChan) begin
        r.status = STATUS_REJECT;
      end else if (cmd.period == '0) begin
        chan_clear(c);
      end else if (cmd.period < 2 || cmd.duty > cmd.period) begin
        r.status = STATUS_REJECT;
      end else begin
        // a fresh channel starts from zero period, duty and count
        if (!chan_en[c]) begin
          chan_clear(c);
          chan_en[c] = 1'b1;
        end
        if (!(chan_period[c] == cmd.period && chan_duty[c] == cmd.duty)) begin
          chan_period[c] = cmd.period;
          chan_duty[c]   = cmd.duty;
          if (chan_count[c] == '0 || chan_count[c] > cmd.period) begin
            chan_phase[c] = 1'b1;
            chan_level[c] = 1'b1;
            chan_count[c] = cmd.duty;
          end
          if (cmd.duty == '0 || cmd.duty == cmd.period) begin
            chan_level[c] = (cmd.duty == cmd.period);
          end
        end
      end
    end else begin
      for (int i = 0; i < NChan; i++) begin
        if (chan_running(i)) begin
          chan_count[i] = chan_count[i] - 1'b1;
          if (chan_count[i] == '0) begin
            chan_phase[i] = ~chan_phase[i];
            chan_level[i] = chan_phase[i];
            chan_count[i] = chan_phase[i] ? chan_duty[i] : chan_period[i] - chan_duty[i];
          end
        end
      end
    end
    for (int i = 0; i < NChan; i++) begin
      r.levels[i] = chan_level[i];
      if (chan_running(i)) r.toggling = 1'b1;
    end
    return r;
  endfunction

  task automatic add_cmd(op_e op, int unsigned ch, int unsigned per, int unsigned dut);
    pwm_cmd_t cmd;
    cmd.op     = op;
    cmd.chan   = ch[ChanW-1:0];
    cmd.period = per[ValueW-1:0];
    cmd.duty   = dut[ValueW-1:0];
    cmd_q.push_back(cmd);
  endtask

  // sender
  always @(negedge clk_i) begin : driver
    pwm_cmd_t nxt;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      in_taken = 1'b0;
      if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        nxt = cmd_q.pop_front();
        in_valid_i  <= 1'b1;
        operation_i <= nxt.op;
        channel_i   <= nxt.chan;
        period_i    <= nxt.period;
        duty_i      <= nxt.duty;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && accepted >= HoldAt) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // monitor and check
  always @(posedge clk_i) begin : monitor
    pwm_cmd_t got;
    pwm_out_t exp_res;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: levels %h", levels_o);
          errors++;
        end else begin
          exp_res = pending_results.pop_front();
          if (levels_o !== exp_res.levels) begin
            $error("levels: expected %h, got %h", exp_res.levels, levels_o);
            errors++;
          end
          if (status_o !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status_o);
            errors++;
          end
          if (toggling_o !== exp_res.toggling) begin
            $error("toggling: expected %0d, got %0d", exp_res.toggling, toggling_o);
            errors++;
          end
          if (exp_res.toggling) n_toggling++;
        end
        checked++;
      end
      if (in_valid_i && !in_ready_o) stall_cycles++;
      if (in_valid_i && in_ready_o) begin
        got.op     = op_e'(operation_i);
        got.chan   = channel_i;
        got.period = period_i;
        got.duty   = duty_i;
        exp_res = pwm_predict(got);
        pending_results.push_back(exp_res);
        if (got.op == OP_SET) n_sets++;
        else n_ticks++;
        if (exp_res.status == STATUS_REJECT) n_rejected++;
        in_taken = 1'b1;
        accepted++;
      end
    end
  end

  initial begin : stimulus
    int unsigned sel;
    int unsigned per;
    for (int i = 0; i < NChan; i++) chan_clear(i);

    // directed
    add_cmd(OP_TICK, 15, 16'hffff, 16'hffff);
    add_cmd(OP_SET, 3, 0, 5);                   // disable an idle channel
    add_cmd(OP_SET, 3, 1, 0);                   // period too short
    add_cmd(OP_SET, 3, 10, 11);                 // duty above period
    add_cmd(OP_SET, 0, 2, 1);
    add_cmd(OP_TICK, 0, 0, 0);
    add_cmd(OP_TICK, 0, 0, 0);
    add_cmd(OP_TICK, 0, 0, 0);
    add_cmd(OP_SET, 0, 2, 1);                   // same setting again
    add_cmd(OP_SET, 15, 16'hffff, 16'hffff);    // static high
    add_cmd(OP_SET, 7, 5, 0);                   // static low
    add_cmd(OP_SET, 1, 16'hffff, 1);
    add_cmd(OP_TICK, 5, 16'haaaa, 16'h5555);
    add_cmd(OP_SET, 1, 3, 2);                   // counter above new period
    add_cmd(OP_TICK, 10, 16'h5555, 16'haaaa);
    add_cmd(OP_TICK, 0, 0, 0);
    add_cmd(OP_SET, 1, 0, 16'hffff);
    add_cmd(OP_SET, 15, 0, 0);
    add_cmd(OP_SET, 0, 16'hffff, 0);
    add_cmd(OP_TICK, 0, 0, 0);
    add_cmd(OP_SET, 4, 16'hffff, 16'hfffe);
    add_cmd(OP_SET, 4, 2, 3);
    add_cmd(OP_TICK, 0, 0, 0);

    // random: mostly ticks and small valid sets so channels really toggle
    for (int n = 0; n < RandItems; n++) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        add_cmd(OP_TICK, $urandom_range(15), $urandom_range(16'hffff), $urandom_range(16'hffff));
      end else if (sel < 82) begin
        per = $urandom_range(12, 2);
        add_cmd(OP_SET, $urandom_range(15), per, $urandom_range(per));
      end else if (sel < 90) begin
        per = $urandom_range(16'hffff, 2);
        add_cmd(OP_SET, $urandom_range(15), per,
                ($urandom_range(3) == 0) ? per : $urandom_range(per));
      end else if (sel < 95) begin
        per = $urandom_range(16'hfffe, 1);
        if (per == 1 || $urandom_range(1) == 0) begin
          add_cmd(OP_SET, $urandom_range(15), 1, $urandom_range(16'hffff));
        end else begin
          add_cmd(OP_SET, $urandom_range(15), per, $urandom_range(16'hffff, per + 1));
        end
      end else begin
        add_cmd(OP_SET, $urandom_range(15), 0, $urandom_range(16'hffff));
      end
    end
    total_items = cmd_q.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted < total_items) @(posedge clk_i);
    while (checked < accepted) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end

    $display("covered %0d items: %0d ticks, %0d set commands (%0d rejected)",
             accepted, n_ticks, n_sets, n_rejected);
    $display("%0d results with a channel toggling, intake stalled for %0d cycles",
             n_toggling, stall_cycles);
    if (errors == 0) begin
      $display("multi_channel_tick_pwm verification clean");
    end else begin
      $display("multi_channel_tick_pwm verification failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("multi_channel_tick_pwm verification failed");
    $finish;
  end

endmodule

`default_nettype wire
